FILE: sv/rpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpa_pkg: shared types and codes of the reference-counted page allocator
// Request and result payloads, operation, status and register index codes.
// ----------------------------------------------------------------------------
package rpa_pkg;

    localparam int PAGE_W   = 10;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;
    localparam int RCOUNT_W = 8;
    localparam int FREE_W   = 11;
    localparam int CFG_W    = 11;
    localparam int LIMIT_W  = 11;

    localparam logic [OP_W-1:0] OP_ALLOC = 3'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 3'd1;
    localparam logic [OP_W-1:0] OP_INCR  = 3'd2;
    localparam logic [OP_W-1:0] OP_DECR  = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    localparam logic CFG_FIRST_PAGE = 1'b0;
    localparam logic CFG_PAGE_LIMIT = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [PAGE_W-1:0] page;
    } t_in_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   result_page;
        logic [RCOUNT_W-1:0] ref_count;
        logic [FREE_W-1:0]   free_pages;
        logic                pushed;
    } t_out_rsp;

    // Side effects of one operation on the two memories and the stack pointer.
    typedef struct packed {
        logic cnt_we;
        logic pop;
        logic push;
    } t_exec_ctl;

endpackage : rpa_pkg
`default_nettype wire

FILE: sv/rpa_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpa_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module rpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule : rpa_ram
`default_nettype wire

FILE: sv/rpa_exec.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpa_exec: operation logic of the page allocator
// Works out the result, the new count and the stack update of one request
// from the count and stack top read out of the memories.
// ----------------------------------------------------------------------------
module rpa_exec #(
    parameter int NUM_PAGES  = 1024,
    parameter int COUNT_BITS = 8
) (
    input  wire rpa_pkg::t_in_req                  i_req,
    input  wire logic [COUNT_BITS-1:0]             i_cnt,
    input  wire logic [rpa_pkg::PAGE_W-1:0]        i_top,
    input  wire logic [$clog2(NUM_PAGES+1)-1:0]    i_depth,
    input  wire logic [rpa_pkg::PAGE_W-1:0]        i_first_page,
    input  wire logic [rpa_pkg::LIMIT_W-1:0]       i_page_limit,
    output rpa_pkg::t_out_rsp                      o_rsp,
    output rpa_pkg::t_exec_ctl                     o_ctl,
    output logic [$clog2(NUM_PAGES)-1:0]           o_cnt_addr,
    output logic [COUNT_BITS-1:0]                  o_cnt_wdata,
    output logic [$clog2(NUM_PAGES+1)-1:0]         o_new_depth
);
    import rpa_pkg::*;

    localparam int ADDR_W  = $clog2(NUM_PAGES);
    localparam int DEPTH_W = $clog2(NUM_PAGES + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    logic [31:0]           w_pg_ext;
    logic [31:0]           w_top_ext;
    logic [31:0]           w_depth_ext;
    logic                  w_valid;
    logic                  w_room;
    logic [COUNT_BITS-1:0] w_c;
    logic [31:0]           w_cnt_ext;
    logic [31:0]           w_new_depth_ext;

    assign w_pg_ext    = 32'(i_req.page);
    assign w_top_ext   = 32'(i_top);
    assign w_depth_ext = 32'(i_depth);
    assign w_room      = w_depth_ext < 32'(NUM_PAGES);
    assign w_valid     = (i_req.page >= i_first_page)
                      && ({1'b0, i_req.page} < i_page_limit)
                      && (w_pg_ext < 32'(NUM_PAGES));

    always_comb begin
        o_rsp.status      = ST_OK;
        o_rsp.result_page = i_req.page;
        o_rsp.pushed      = 1'b0;
        o_ctl             = '0;
        o_cnt_addr        = w_pg_ext[ADDR_W-1:0];
        w_c               = i_cnt;
        w_cnt_ext         = '0;

        if (i_req.op == OP_ALLOC) begin
            if (i_depth == '0) begin
                o_rsp.status      = ST_EMPTY;
                o_rsp.result_page = '0;
            end else begin
                o_ctl.pop         = 1'b1;
                o_rsp.result_page = i_top;
                o_cnt_addr        = w_top_ext[ADDR_W-1:0];
                w_c               = COUNT_ONE;
                if (w_top_ext < 32'(NUM_PAGES)) begin
                    o_ctl.cnt_we = 1'b1;
                    w_cnt_ext    = 32'(w_c);
                end
            end
        end else if (!w_valid) begin
            o_rsp.status = ST_RANGE;
        end else begin
            o_ctl.cnt_we = 1'b1;
            case (i_req.op)
                OP_FREE: begin
                    if (i_cnt > COUNT_ONE) begin
                        w_c = i_cnt - COUNT_ONE;
                    end else if (w_room) begin
                        w_c          = '0;
                        o_ctl.push   = 1'b1;
                        o_rsp.pushed = 1'b1;
                    end else begin
                        o_rsp.status = ST_FULL;
                        o_ctl.cnt_we = 1'b0;
                    end
                end
                OP_INCR: begin
                    if (i_cnt != COUNT_MAX) begin
                        w_c = i_cnt + COUNT_ONE;
                    end
                end
                OP_DECR: begin
                    if (i_cnt > COUNT_ONE) begin
                        w_c = i_cnt - COUNT_ONE;
                    end else if (i_cnt == COUNT_ONE) begin
                        if (w_room) begin
                            w_c          = '0;
                            o_ctl.push   = 1'b1;
                            o_rsp.pushed = 1'b1;
                        end else begin
                            o_rsp.status = ST_FULL;
                            o_ctl.cnt_we = 1'b0;
                        end
                    end
                end
                default: begin
                    // Query and the unused codes leave the count as it is.
                    w_c = i_cnt;
                end
            endcase
            w_cnt_ext = 32'(w_c);
        end

        o_cnt_wdata     = w_c;
        o_rsp.ref_count = w_cnt_ext[RCOUNT_W-1:0];

        o_new_depth = i_depth;
        if (o_ctl.pop) begin
            o_new_depth = i_depth - DEPTH_W'(1);
        end else if (o_ctl.push) begin
            o_new_depth = i_depth + DEPTH_W'(1);
        end
        w_new_depth_ext  = 32'(o_new_depth);
        o_rsp.free_pages = w_new_depth_ext[FREE_W-1:0];
    end

endmodule : rpa_exec
`default_nettype wire

FILE: sv/refcounted_page_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// refcounted_page_allocator_unit: page frame allocator with reference counts
// LIFO free stack of page numbers plus a per-page reference count table.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  in        input      i_in_valid / o_in_ready   t_in_req  (op, page)
//  out       output     o_out_valid / i_out_ready t_out_rsp (one per request)
//  cfg       input      i_cfg_we                  index + 11-bit data
//
//  Each request is accepted in S_IDLE, where the accept launches the count and
//  stack reads, and is then executed in S_EXEC, which updates both memories
//  and loads the result register. The registered read of the count RAM is why
//  the update waits for S_EXEC. After reset a clearing pass zeroes every entry
//  of the count table with o_in_ready low. A result waiting on the output does
//  not block the next accept; only the update stalls until the register frees.
// ----------------------------------------------------------------------------
module refcounted_page_allocator_unit #(
    parameter int NUM_PAGES  = 1024,
    parameter int COUNT_BITS = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire rpa_pkg::t_in_req            i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output rpa_pkg::t_out_rsp                o_out_data,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_index,
    input  wire logic [rpa_pkg::CFG_W-1:0]   i_cfg_data
);
    import rpa_pkg::*;

    localparam int ADDR_W  = $clog2(NUM_PAGES);
    localparam int DEPTH_W = $clog2(NUM_PAGES + 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_PAGES - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state               r_state;
    t_in_req              r_req;
    t_out_rsp             r_out_data;
    logic                 r_out_valid;
    logic [DEPTH_W-1:0]   r_depth;
    logic [ADDR_W-1:0]    r_clr_idx;
    logic [PAGE_W-1:0]    r_first_page;
    logic [LIMIT_W-1:0]   r_page_limit;

    t_out_rsp             w_rsp;
    t_exec_ctl            w_ctl;
    logic [ADDR_W-1:0]    w_cnt_addr;
    logic [COUNT_BITS-1:0] w_cnt_wdata;
    logic [COUNT_BITS-1:0] w_cnt_rd;
    logic [PAGE_W-1:0]    w_top_rd;
    logic [DEPTH_W-1:0]   n_depth;
    logic                 w_done;
    logic [31:0]          w_rd_pg_ext;
    logic [ADDR_W-1:0]    w_cnt_raddr;
    logic [DEPTH_W-1:0]   w_top_idx;
    logic                 w_cnt_we;
    logic [ADDR_W-1:0]    w_cnt_waddr;
    logic [COUNT_BITS-1:0] w_cnt_wd;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign w_done      = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    // The count read is launched straight from the port in the accept cycle.
    assign w_rd_pg_ext = (r_state == S_IDLE) ? 32'(i_in_data.page) : 32'(r_req.page);
    assign w_cnt_raddr = w_rd_pg_ext[ADDR_W-1:0];
    assign w_top_idx   = r_depth - DEPTH_W'(1);

    assign w_cnt_we    = (r_state == S_CLEAR) || (w_done && w_ctl.cnt_we);
    assign w_cnt_waddr = (r_state == S_CLEAR) ? r_clr_idx : w_cnt_addr;
    assign w_cnt_wd    = (r_state == S_CLEAR) ? '0 : w_cnt_wdata;

    rpa_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_PAGES)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (w_cnt_we),
        .i_waddr (w_cnt_waddr),
        .i_wdata (w_cnt_wd),
        .i_raddr (w_cnt_raddr),
        .o_rdata (w_cnt_rd)
    );

    rpa_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (NUM_PAGES)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (w_done && w_ctl.push),
        .i_waddr (r_depth[ADDR_W-1:0]),
        .i_wdata (r_req.page),
        .i_raddr (w_top_idx[ADDR_W-1:0]),
        .o_rdata (w_top_rd)
    );

    rpa_exec #(
        .NUM_PAGES  (NUM_PAGES),
        .COUNT_BITS (COUNT_BITS)
    ) u_exec (
        .i_req        (r_req),
        .i_cnt        (w_cnt_rd),
        .i_top        (w_top_rd),
        .i_depth      (r_depth),
        .i_first_page (r_first_page),
        .i_page_limit (r_page_limit),
        .o_rsp        (w_rsp),
        .o_ctl        (w_ctl),
        .o_cnt_addr   (w_cnt_addr),
        .o_cnt_wdata  (w_cnt_wdata),
        .o_new_depth  (n_depth)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + ADDR_W'(1);
                    if (r_clr_idx == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req   <= i_in_data;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_done) begin
                        r_out_data  <= w_rsp;
                        r_depth     <= n_depth;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_page <= '0;
            r_page_limit <= LIMIT_W'(1024);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FIRST_PAGE: r_first_page <= i_cfg_data[PAGE_W-1:0];
                CFG_PAGE_LIMIT: r_page_limit <= i_cfg_data[LIMIT_W-1:0];
                default: begin
                    r_first_page <= r_first_page;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_depth_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_depth) <= 32'(NUM_PAGES))
        else $error("free stack depth exceeds the number of pages");

    a_result_from_exec : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EXEC))
        else $error("result appeared without a request in execution");

    a_push_is_ok : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.pushed) |-> (o_out_data.status == ST_OK))
        else $error("page pushed on a failed request");

    a_depth_moves_on_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_EXEC) |=> $stable(r_depth) || $past(r_state == S_EXEC))
        else $error("stack depth changed outside an update");
`endif

endmodule : refcounted_page_allocator_unit
`default_nettype wire

FILE: tb/sv/refcounted_page_allocator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_page_allocator_unit_tb: self-checking bench for the page allocator
// A directed table walks the empty stack, saturation, repeated free,
// clamped decrement and range checks. Random traffic then runs under several
// range settings. Every result is compared field by field with the value that
// its directed row gives or else with a cycle-free model of the allocator.
// ----------------------------------------------------------------------------
module refcounted_page_allocator_unit_tb;
    import rpa_pkg::*;

    localparam int NUM_PAGES       = 1024;
    localparam int COUNT_BITS      = 8;
    localparam int COUNT_MAX       = (1 << COUNT_BITS) - 1;
    localparam int PRESSURE_CYCLES = 120;
    localparam int PRESSURE_AT     = 120;

    // Opcodes without a name in the package decode as a query.
    localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        t_in_req     rq;
        logic        cfg_idx;
        int unsigned value;
        int          reps;
        bit          typed;
        t_out_rsp    rsp;
    } t_stim_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    t_in_req           i_in_data;
    logic              o_out_valid;
    logic              i_out_ready;
    t_out_rsp          o_out_data;
    logic              i_cfg_we;
    logic              i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_data;

    // Shadow state of the allocator.
    logic [PAGE_W-1:0] shadow_stack [NUM_PAGES];
    int unsigned       shadow_count [NUM_PAGES];
    int unsigned       shadow_depth;
    int unsigned       shadow_first;
    int unsigned       shadow_limit;
    logic [PAGE_W-1:0] last_alloc;
    logic [PAGE_W-1:0] page_pool [8];

    t_out_rsp          pending_rsp_q [$];
    t_stim_row         dir_rows [$];

    int errors, n_requests, n_checked, n_cfg_writes;
    int n_full, n_empty, n_range, n_pushed;
    bit no_idle;

    refcounted_page_allocator_unit #(
        .NUM_PAGES  (NUM_PAGES),
        .COUNT_BITS (COUNT_BITS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void push_free(logic [PAGE_W-1:0] pg);
        shadow_stack[shadow_depth] = pg;
        shadow_depth++;
        n_pushed++;
    endfunction

    // Expected result of one request; updates the shadow state as the block would.
    function automatic t_out_rsp predict_rsp(t_in_req rq);
        t_out_rsp    r;
        int unsigned c;
        r = '0;
        if (rq.op == OP_ALLOC) begin
            if (shadow_depth == 0) begin
                r.status = ST_EMPTY;
                n_empty++;
            end else begin
                shadow_depth--;
                r.result_page = shadow_stack[shadow_depth];
                shadow_count[r.result_page] = 1;
                r.ref_count = 8'd1;
                last_alloc = r.result_page;
            end
        end else begin
            r.result_page = rq.page;
            if (rq.page < shadow_first || rq.page >= shadow_limit) begin
                r.status = ST_RANGE;
                n_range++;
            end else begin
                c = shadow_count[rq.page];
                case (rq.op)
                    OP_FREE: begin
                        if (c > 1) c--;
                        else if (shadow_depth < NUM_PAGES) begin
                            push_free(rq.page);
                            c = 0;
                            r.pushed = 1'b1;
                        end else begin
                            r.status = ST_FULL;
                            n_full++;
                        end
                    end
                    OP_INCR: begin
                        if (c < COUNT_MAX) c++;
                    end
                    OP_DECR: begin
                        if (c > 1) c--;
                        else if (c == 1) begin
                            if (shadow_depth < NUM_PAGES) begin
                                push_free(rq.page);
                                c = 0;
                                r.pushed = 1'b1;
                            end else begin
                                r.status = ST_FULL;
                                n_full++;
                            end
                        end
                    end
                    default: ;
                endcase
                shadow_count[rq.page] = c;
                r.ref_count = c[RCOUNT_W-1:0];
            end
        end
        r.free_pages = shadow_depth[FREE_W-1:0];
        return r;
    endfunction

    function automatic t_stim_row mk_req(logic [OP_W-1:0] op, int unsigned pg, int reps);
        t_stim_row row;
        row = '{kind: ROW_REQ, rq: '0, cfg_idx: 1'b0, value: 0, reps: reps,
                typed: 1'b0, rsp: '0};
        row.rq.op   = op;
        row.rq.page = pg[PAGE_W-1:0];
        return row;
    endfunction

    function automatic t_stim_row mk_chk(logic [OP_W-1:0] op, int unsigned pg,
                                         logic [STATUS_W-1:0] st, int unsigned rpage,
                                         int unsigned cnt, int unsigned free_n, bit psh);
        t_stim_row row;
        row = mk_req(op, pg, 1);
        row.typed           = 1'b1;
        row.rsp.status      = st;
        row.rsp.result_page = rpage[PAGE_W-1:0];
        row.rsp.ref_count   = cnt[RCOUNT_W-1:0];
        row.rsp.free_pages  = free_n[FREE_W-1:0];
        row.rsp.pushed      = psh;
        return row;
    endfunction

    function automatic t_stim_row mk_cfg(logic idx, int unsigned value);
        t_stim_row row;
        row = mk_req(OP_QUERY, 0, 0);
        row.kind    = ROW_CFG;
        row.cfg_idx = idx;
        row.value   = value;
        return row;
    endfunction

    task automatic send_req(input t_in_req rq, input bit typed, input t_out_rsp typed_rsp);
        t_out_rsp want;
        int       gap;
        bit       taken;
        want = predict_rsp(rq);
        pending_rsp_q.push_back(typed ? typed_rsp : want);
        n_requests++;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = rq;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = o_in_ready;
            @(negedge i_clk);
        end
    endtask

    // Registers change only once every outstanding request has its result.
    task automatic cfg_write(input logic idx, input int unsigned value);
        i_in_valid = 1'b0;
        while (pending_rsp_q.size() != 0) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_FIRST_PAGE) shadow_first = value & 32'h3FF;
        else shadow_limit = value & 32'h7FF;
        n_cfg_writes++;
    endtask

    task automatic fill_pool();
        for (int i = 0; i < 8; i++) begin
            if (shadow_first < shadow_limit)
                page_pool[i] = PAGE_W'($urandom_range(shadow_first, shadow_limit - 1));
            else
                page_pool[i] = PAGE_W'($urandom_range(0, NUM_PAGES - 1));
        end
    endtask

    task automatic send_random();
        t_in_req rq;
        int      r;
        r = $urandom_range(0, 99);
        if (r < 20)      rq.op = OP_ALLOC;
        else if (r < 45) rq.op = OP_FREE;
        else if (r < 65) rq.op = OP_INCR;
        else if (r < 85) rq.op = OP_DECR;
        else if (r < 95) rq.op = OP_QUERY;
        else             rq.op = OP_W'($urandom_range(OP_RSVD5, OP_RSVD7));
        r = $urandom_range(0, 99);
        if (r < 70)      rq.page = page_pool[$urandom_range(0, 7)];
        else if (r < 85) rq.page = last_alloc;
        else             rq.page = PAGE_W'($urandom_range(0, NUM_PAGES - 1));
        send_req(rq, 1'b0, '0);
    endtask

    // Receiver handshake, with one long hold-off to back the block up.
    initial begin
        int stall_left;
        int burst_left;
        bit pressure_done;
        stall_left    = 0;
        burst_left    = 0;
        pressure_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!pressure_done && n_checked >= PRESSURE_AT) begin
                pressure_done = 1'b1;
                stall_left    = PRESSURE_CYCLES;
                burst_left    = 0;
            end
            if (stall_left == 0 && burst_left == 0 && !no_idle) begin
                stall_left = pick_gap();
                burst_left = $urandom_range(1, 8);
            end
            if (stall_left > 0) begin
                i_out_ready = 1'b0;
                stall_left--;
            end else begin
                i_out_ready = 1'b1;
                if (burst_left > 0) burst_left--;
            end
        end
    end

    initial begin
        t_out_rsp want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                n_checked++;
                if (pending_rsp_q.size() == 0) begin
                    $display("%0t: result with no request outstanding: %p", $realtime,
                             o_out_data);
                    errors++;
                end else begin
                    want = pending_rsp_q.pop_front();
                    if (o_out_data.status !== want.status) begin
                        $display("%0t: status expected %0d got %0d", $realtime,
                                 want.status, o_out_data.status);
                        errors++;
                    end
                    if (o_out_data.result_page !== want.result_page) begin
                        $display("%0t: result_page expected %0d got %0d", $realtime,
                                 want.result_page, o_out_data.result_page);
                        errors++;
                    end
                    if (o_out_data.ref_count !== want.ref_count) begin
                        $display("%0t: ref_count expected %0d got %0d", $realtime,
                                 want.ref_count, o_out_data.ref_count);
                        errors++;
                    end
                    if (o_out_data.free_pages !== want.free_pages) begin
                        $display("%0t: free_pages expected %0d got %0d", $realtime,
                                 want.free_pages, o_out_data.free_pages);
                        errors++;
                    end
                    if (o_out_data.pushed !== want.pushed) begin
                        $display("%0t: pushed expected %0d got %0d", $realtime,
                                 want.pushed, o_out_data.pushed);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        int unsigned pf, pl;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_data  = '0;
        no_idle     = 1'b0;
        errors = 0; n_requests = 0; n_checked = 0; n_cfg_writes = 0;
        n_full = 0; n_empty = 0; n_range = 0; n_pushed = 0;
        shadow_depth = 0;
        shadow_first = 0;
        shadow_limit = NUM_PAGES;
        last_alloc   = '0;
        for (int i = 0; i < NUM_PAGES; i++) begin
            shadow_count[i] = 0;
            shadow_stack[i] = '0;
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table: empty stack, repeated free, clamped decrement,
        // saturation, spare opcodes, unchecked alloc range and range errors.
        dir_rows.push_back(mk_cfg(CFG_FIRST_PAGE, 0));
        dir_rows.push_back(mk_cfg(CFG_PAGE_LIMIT, NUM_PAGES));
        dir_rows.push_back(mk_chk(OP_ALLOC, 1023, ST_EMPTY, 0, 0, 0, 0));
        dir_rows.push_back(mk_chk(OP_QUERY, 0, ST_OK, 0, 0, 0, 0));
        dir_rows.push_back(mk_chk(OP_QUERY, 1023, ST_OK, 1023, 0, 0, 0));
        dir_rows.push_back(mk_chk(OP_FREE, 1023, ST_OK, 1023, 0, 1, 1));
        dir_rows.push_back(mk_chk(OP_INCR, 1023, ST_OK, 1023, 1, 1, 0));
        dir_rows.push_back(mk_chk(OP_ALLOC, 0, ST_OK, 1023, 1, 0, 0));
        dir_rows.push_back(mk_chk(OP_DECR, 1023, ST_OK, 1023, 0, 1, 1));
        dir_rows.push_back(mk_chk(OP_DECR, 1023, ST_OK, 1023, 0, 1, 0));
        dir_rows.push_back(mk_chk(OP_FREE, 0, ST_OK, 0, 0, 2, 1));
        dir_rows.push_back(mk_chk(OP_FREE, 0, ST_OK, 0, 0, 3, 1));
        dir_rows.push_back(mk_req(OP_ALLOC, 341, 1));
        dir_rows.push_back(mk_req(OP_INCR, 0, 1));
        dir_rows.push_back(mk_req(OP_FREE, 0, 1));
        dir_rows.push_back(mk_req(OP_INCR, 682, COUNT_MAX + 5));
        dir_rows.push_back(mk_chk(OP_QUERY, 682, ST_OK, 682, COUNT_MAX, 2, 0));
        dir_rows.push_back(mk_req(OP_DECR, 682, 1));
        dir_rows.push_back(mk_req(OP_RSVD5, 341, 1));
        dir_rows.push_back(mk_req(OP_RSVD6, 0, 1));
        dir_rows.push_back(mk_req(OP_RSVD7, 1023, 1));
        dir_rows.push_back(mk_cfg(CFG_FIRST_PAGE, 1023));
        dir_rows.push_back(mk_chk(OP_FREE, 1022, ST_RANGE, 1022, 0, 2, 0));
        dir_rows.push_back(mk_req(OP_INCR, 1023, 1));
        dir_rows.push_back(mk_cfg(CFG_FIRST_PAGE, 512));
        dir_rows.push_back(mk_cfg(CFG_PAGE_LIMIT, 600));
        dir_rows.push_back(mk_req(OP_ALLOC, 0, 1));
        dir_rows.push_back(mk_req(OP_ALLOC, 682, 1));
        dir_rows.push_back(mk_chk(OP_ALLOC, 1023, ST_EMPTY, 0, 0, 0, 0));
        dir_rows.push_back(mk_chk(OP_FREE, 0, ST_RANGE, 0, 0, 0, 0));
        dir_rows.push_back(mk_chk(OP_FREE, 600, ST_RANGE, 600, 0, 0, 0));
        dir_rows.push_back(mk_req(OP_QUERY, 599, 1));
        dir_rows.push_back(mk_cfg(CFG_FIRST_PAGE, 0));
        dir_rows.push_back(mk_cfg(CFG_PAGE_LIMIT, 1));
        dir_rows.push_back(mk_chk(OP_FREE, 1, ST_RANGE, 1, 0, 0, 0));
        dir_rows.push_back(mk_req(OP_FREE, 0, 1));
        dir_rows.push_back(mk_cfg(CFG_FIRST_PAGE, 500));
        dir_rows.push_back(mk_cfg(CFG_PAGE_LIMIT, 300));
        dir_rows.push_back(mk_chk(OP_QUERY, 400, ST_RANGE, 400, 0, 1, 0));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG)
                cfg_write(dir_rows[i].cfg_idx, dir_rows[i].value);
            else
                repeat (dir_rows[i].reps)
                    send_req(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].rsp);
        end

        // Random traffic under a sequence of range settings.
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin pf = 0;    pl = NUM_PAGES;     end
                1: begin pf = 100;  pl = 200;           end
                2: begin pf = 1023; pl = NUM_PAGES;     end
                3: begin pf = 0;    pl = 1;             end
                4: begin pf = 0;    pl = NUM_PAGES - 1; end
                default: begin
                    pf = $urandom_range(0, NUM_PAGES - 1);
                    pl = $urandom_range(1, NUM_PAGES);
                end
            endcase
            cfg_write(CFG_FIRST_PAGE, pf);
            cfg_write(CFG_PAGE_LIMIT, pl);
            fill_pool();
            no_idle = (p == 4);
            repeat (15) send_random();
        end
        no_idle = 1'b0;

        i_in_valid = 1'b0;
        while (pending_rsp_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Ran %0d requests, checked %0d results across %0d register writes.",
                 n_requests, n_checked, n_cfg_writes);
        $display("Saw %0d stack-full, %0d empty, %0d out-of-range results, %0d pushes.",
                 n_full, n_empty, n_range, n_pushed);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/rpa_pkg.sv
sv/rpa_ram.sv
sv/rpa_exec.sv
sv/refcounted_page_allocator_unit.sv
tb/sv/refcounted_page_allocator_unit_tb.sv
